FILE: design/pfa_pkg.sv
// ----------------------------------------------------------------------------
// pfa_pkg
// Shared types and codes of the page frame allocator.
// ----------------------------------------------------------------------------
package pfa_pkg;

  localparam logic [2:0] ST_MAPPED  = 3'd0;
  localparam logic [2:0] ST_FREED   = 3'd1;
  localparam logic [2:0] ST_UNKNOWN = 3'd2;
  localparam logic [2:0] ST_TOOBIG  = 3'd3;
  localparam logic [2:0] ST_SHORT   = 3'd4;
  localparam logic [2:0] ST_BUSY    = 3'd5;

  localparam logic REQ_ALLOC   = 1'b0;
  localparam logic REQ_RELEASE = 1'b1;

  localparam logic REG_FRAME_SIZE  = 1'b0;
  localparam logic REG_FRAME_COUNT = 1'b1;

  localparam int SIZE_W = 17;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHK_SLOT,
    S_DIV,
    S_CHK_SIZE,
    S_READ,
    S_EMIT,
    S_ERR
  } state_e;

  typedef struct packed {
    logic       load;
    logic       div_start;
    logic       start_rel;
    logic       start_alloc;
    logic       rd;
    logic       emit_page;
    logic       emit_err;
    logic [2:0] err_code;
  } cmd_t;

  typedef struct packed {
    logic req_type;
    logic slot_bad;
    logic slot_busy;
    logic rel_bad;
    logic too_large;
    logic short_frames;
    logic div_done;
    logic last_page;
    logic out_free;
  } sts_t;

endpackage

FILE: design/pfa_ctrl.sv
// ----------------------------------------------------------------------------
// pfa_ctrl
// Request sequencer: checks, divide wait, per-page read and emit.
// ----------------------------------------------------------------------------
module pfa_ctrl import pfa_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  sts_t sts_i,
  output cmd_t cmd_o
);

  state_e     state_q, state_d;
  logic [2:0] err_q, err_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      err_q   <= ST_UNKNOWN;
    end else begin
      state_q <= state_d;
      err_q   <= err_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    err_d      = err_q;
    cmd_o      = '0;
    cmd_o.err_code = err_q;
    in_ready_o = 1'b0;
    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_CHK_SLOT;
        end
      end
      S_CHK_SLOT: begin
        if (sts_i.slot_bad) begin
          err_d = ST_UNKNOWN; state_d = S_ERR;
        end else if (sts_i.req_type == REQ_RELEASE) begin
          if (sts_i.rel_bad) begin
            err_d = ST_UNKNOWN; state_d = S_ERR;
          end else begin
            cmd_o.start_rel = 1'b1; state_d = S_READ;
          end
        end else if (sts_i.slot_busy) begin
          err_d = ST_BUSY; state_d = S_ERR;
        end else begin
          cmd_o.div_start = 1'b1; state_d = S_DIV;
        end
      end
      S_DIV: begin
        if (sts_i.div_done) state_d = S_CHK_SIZE;
      end
      S_CHK_SIZE: begin
        if (sts_i.too_large) begin
          err_d = ST_TOOBIG; state_d = S_ERR;
        end else if (sts_i.short_frames) begin
          err_d = ST_SHORT; state_d = S_ERR;
        end else begin
          cmd_o.start_alloc = 1'b1; state_d = S_READ;
        end
      end
      S_READ: begin
        cmd_o.rd = 1'b1;
        state_d  = S_EMIT;
      end
      S_EMIT: begin
        if (sts_i.out_free) begin
          cmd_o.emit_page = 1'b1;
          state_d = sts_i.last_page ? S_IDLE : S_READ;
        end
      end
      S_ERR: begin
        if (sts_i.out_free) begin
          cmd_o.emit_err = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

endmodule

FILE: design/pfa_dp.sv
// ----------------------------------------------------------------------------
// pfa_dp
// Datapath: registers, free list, page tables, divider and output register.
// ----------------------------------------------------------------------------
module pfa_dp import pfa_pkg::*; #(
  parameter int FRAMES     = 64,
  parameter int MAX_PAGES  = 16,
  parameter int PROC_SLOTS = 8
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  cmd_t        cmd_i,
  output sts_t        sts_o,
  input  logic        in_type_i,
  input  logic [2:0]  in_slot_i,
  input  logic [15:0] in_size_i,
  input  logic        cfg_wr_i,
  input  logic        cfg_idx_i,
  input  logic [31:0] cfg_wdata_i,
  output logic [31:0] cfg_rdata_o,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [2:0]  out_status_o,
  output logic [3:0]  out_page_o,
  output logic [25:0] out_addr_o,
  output logic        out_last_o
);

  localparam int FW   = (FRAMES > 1) ? $clog2(FRAMES) : 1;
  localparam int CNTW = $clog2(FRAMES + 1);
  localparam int PCW  = $clog2(MAX_PAGES + 1);
  localparam int SLW  = (PROC_SLOTS > 1) ? $clog2(PROC_SLOTS) : 1;
  localparam int MAPD = PROC_SLOTS * MAX_PAGES;
  localparam int MAPW = (MAPD > 1) ? $clog2(MAPD) : 1;

  logic [10:0]       fs_q;
  logic [6:0]        fc_q;
  logic              type_q;
  logic [2:0]        slot_q;
  logic [SIZE_W-1:0] size_q, quo_q;
  logic [11:0]       rem_q;
  logic [4:0]        dcnt_q;
  logic [FW-1:0]     head_q, tail_q;
  logic [CNTW-1:0]   fcnt_q;
  logic [FRAMES-1:0] vld_q;
  logic [PCW-1:0]    held_q [PROC_SLOTS];
  logic [PROC_SLOTS-1:0] used_q;
  logic [PCW-1:0]    pg_q, npg_q;
  logic [FW-1:0]     fifo_mem [FRAMES];
  logic [FW-1:0]     map_mem [MAPD];
  logic [FW-1:0]     fifo_rd_q, idx_rd_q, map_rd_q;
  logic              vld_rd_q;
  logic              ovalid_q, olast_q;
  logic [2:0]        ostat_q;
  logic [3:0]        opage_q;
  logic [25:0]       oaddr_q;

  logic [10:0]       fs;
  logic [CNTW-1:0]   effc, cfg_cnt;
  logic [SIZE_W-1:0] rsize;
  logic [SLW-1:0]    sidx;
  logic [MAPW-1:0]   maddr;
  logic [FW-1:0]     frame;
  logic [FW+10:0]    fprod;
  logic [63:0]       addr64;
  logic [11:0]       rem_sh;
  logic              push_ok;

  function automatic logic [FW-1:0] wrap_inc(input logic [FW-1:0] x);
    return (32'(x) == FRAMES - 1) ? '0 : x + FW'(1);
  endfunction

  function automatic logic [CNTW-1:0] clamp_cnt(input logic [6:0] c);
    if (c == 7'd0) return CNTW'(1);
    if (32'(c) > FRAMES) return CNTW'(FRAMES);
    return CNTW'(c);
  endfunction

  assign fs      = (fs_q == 11'd0) ? 11'd1 : fs_q;
  assign effc    = clamp_cnt(fc_q);
  assign cfg_cnt = clamp_cnt(cfg_wdata_i[6:0]);
  assign sidx    = SLW'(slot_q);
  assign maddr   = MAPW'(32'(sidx) * MAX_PAGES + 32'(pg_q));
  assign frame   = (type_q == REQ_RELEASE) ? map_rd_q : (vld_rd_q ? fifo_rd_q : idx_rd_q);
  assign fprod   = (FW + 11)'(frame * fs);
  assign addr64  = 64'(fprod) << 10;
  assign rem_sh  = {rem_q[10:0], quo_q[SIZE_W-1]};
  assign push_ok = 32'(fcnt_q) < FRAMES;

  always_comb begin
    if ({1'b0, in_size_i} < {6'd0, fs}) rsize = {6'd0, fs};
    else if (in_size_i[0])              rsize = {1'b0, in_size_i} + SIZE_W'(1);
    else                                rsize = {1'b0, in_size_i};
  end

  always_comb begin
    sts_o.req_type     = type_q;
    sts_o.slot_bad     = 32'(slot_q) >= PROC_SLOTS;
    sts_o.slot_busy    = used_q[sidx];
    sts_o.rel_bad      = !used_q[sidx] || held_q[sidx] == '0 ||
                         32'(held_q[sidx]) > MAX_PAGES;
    sts_o.too_large    = 32'(size_q) > 32'(effc) * 32'(fs) || 32'(quo_q) > MAX_PAGES;
    sts_o.short_frames = 32'(quo_q) > 32'(fcnt_q);
    sts_o.div_done     = dcnt_q == 5'd0;
    sts_o.last_page    = pg_q + PCW'(1) == npg_q;
    sts_o.out_free     = !ovalid_q || out_ready_i;
  end

  always_comb begin
    case (cfg_idx_i)
      REG_FRAME_SIZE:  cfg_rdata_o = {21'd0, fs_q};
      REG_FRAME_COUNT: cfg_rdata_o = {25'd0, fc_q};
      default:         cfg_rdata_o = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fs_q     <= 11'd2;
      fc_q     <= 7'd5;
      head_q   <= '0;
      tail_q   <= FW'(32'(clamp_cnt(7'd5)) % FRAMES);
      fcnt_q   <= clamp_cnt(7'd5);
      vld_q    <= '0;
      used_q   <= '0;
      held_q   <= '{default: '0};
      dcnt_q   <= '0;
      ovalid_q <= 1'b0;
    end else begin
      if (cfg_wr_i && cfg_idx_i == REG_FRAME_SIZE) fs_q <= cfg_wdata_i[10:0];
      if (cfg_wr_i && cfg_idx_i == REG_FRAME_COUNT) begin
        fc_q   <= cfg_wdata_i[6:0];
        head_q <= '0;
        tail_q <= (32'(cfg_cnt) == FRAMES) ? '0 : FW'(cfg_cnt);
        fcnt_q <= cfg_cnt;
        vld_q  <= '0;
        used_q <= '0;
        held_q <= '{default: '0};
      end
      if (cmd_i.div_start) begin
        dcnt_q <= 5'(SIZE_W);
      end else if (dcnt_q != 5'd0) begin
        dcnt_q <= dcnt_q - 5'd1;
      end
      if (cmd_i.emit_page) begin
        if (type_q == REQ_RELEASE) begin
          if (push_ok) begin
            vld_q[tail_q] <= 1'b1;
            tail_q <= wrap_inc(tail_q);
            fcnt_q <= fcnt_q + CNTW'(1);
          end
          if (sts_o.last_page) begin
            used_q[sidx] <= 1'b0;
            held_q[sidx] <= '0;
          end
        end else begin
          head_q <= wrap_inc(head_q);
          fcnt_q <= fcnt_q - CNTW'(1);
          if (sts_o.last_page) begin
            used_q[sidx] <= 1'b1;
            held_q[sidx] <= npg_q;
          end
        end
      end
      if (cmd_i.emit_page || cmd_i.emit_err) ovalid_q <= 1'b1;
      else if (out_ready_i)                   ovalid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      type_q <= in_type_i;
      slot_q <= in_slot_i;
      size_q <= rsize;
    end
    if (cmd_i.div_start) begin
      quo_q <= size_q;
      rem_q <= '0;
    end else if (dcnt_q != 5'd0) begin
      if (rem_sh >= {1'b0, fs}) begin
        rem_q <= rem_sh - {1'b0, fs};
        quo_q <= {quo_q[SIZE_W-2:0], 1'b1};
      end else begin
        rem_q <= rem_sh;
        quo_q <= {quo_q[SIZE_W-2:0], 1'b0};
      end
    end
    if (cmd_i.start_rel) begin
      pg_q  <= '0;
      npg_q <= held_q[sidx];
    end
    if (cmd_i.start_alloc) begin
      pg_q  <= '0;
      npg_q <= PCW'(quo_q);
    end
    if (cmd_i.emit_page) pg_q <= pg_q + PCW'(1);
    if (cmd_i.emit_page) begin
      ostat_q <= (type_q == REQ_RELEASE) ? ST_FREED : ST_MAPPED;
      opage_q <= 4'(pg_q);
      oaddr_q <= addr64[25:0];
      olast_q <= sts_o.last_page;
    end else if (cmd_i.emit_err) begin
      ostat_q <= cmd_i.err_code;
      opage_q <= '0;
      oaddr_q <= '0;
      olast_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.rd) begin
      fifo_rd_q <= fifo_mem[head_q];
      vld_rd_q  <= vld_q[head_q];
      idx_rd_q  <= head_q;
      map_rd_q  <= map_mem[maddr];
    end
    if (cmd_i.emit_page && type_q == REQ_RELEASE && push_ok) fifo_mem[tail_q] <= frame;
    if (cmd_i.emit_page && type_q == REQ_ALLOC) map_mem[maddr] <= frame;
  end

  assign out_valid_o  = ovalid_q;
  assign out_status_o = ostat_q;
  assign out_page_o   = opage_q;
  assign out_addr_o   = oaddr_q;
  assign out_last_o   = olast_q;

endmodule

FILE: design/page_frame_allocator.sv
// ----------------------------------------------------------------------------
// page_frame_allocator
// FIFO free-frame list with per-slot page tables.
// ----------------------------------------------------------------------------
// Requests arrive on the s_ stream: tuser carries the request type, tdata the
// slot and size. Each page mapped or frame freed leaves on the m_ stream as
// one transfer; tlast marks the final one of a request. Rejected requests give
// a single error transfer.
// An allocate passes a slot check, the divider (one quotient bit per cycle,
// then a check that the count has run out) and a size check, then for each
// page a table or list memory read, then an emit that waits while the
// output register still holds an untaken transfer. A release passes the slot
// check, then reads and emits each page the same way. One request is handled at a time.
// Reset restores frame size 2 KB, frame count 5 and an empty set of slots;
// no clearing pass is needed. Writing the frame count register rebuilds the
// free list and frees all slots. When the receiver stalls, the output
// register holds its transfer and the sequencer waits before the next emit.
// ----------------------------------------------------------------------------
module page_frame_allocator import pfa_pkg::*; #(
  parameter int FRAMES     = 64,
  parameter int MAX_PAGES  = 16,
  parameter int PROC_SLOTS = 8
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_tvalid_i,
  output logic        s_tready_o,
  input  logic [23:0] s_tdata_i,  // proc_slot[2:0], req_size_kb[18:3], zero pad
  input  logic [0:0]  s_tuser_i,  // req_type[0]
  output logic        m_tvalid_o,
  input  logic        m_tready_i,
  output logic [39:0] m_tdata_o,  // status[2:0], page_index[6:3], frame_addr[32:7], pad
  output logic        m_tlast_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  cmd_t        cmd;
  sts_t        sts;
  logic [2:0]  ostat;
  logic [3:0]  opage;
  logic [25:0] oaddr;

  pfa_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_tvalid_i),
    .in_ready_o (s_tready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  pfa_dp #(
    .FRAMES     (FRAMES),
    .MAX_PAGES  (MAX_PAGES),
    .PROC_SLOTS (PROC_SLOTS)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .in_type_i    (s_tuser_i[0]),
    .in_slot_i    (s_tdata_i[2:0]),
    .in_size_i    (s_tdata_i[18:3]),
    .cfg_wr_i     (psel && penable && pwrite),
    .cfg_idx_i    (paddr[2]),
    .cfg_wdata_i  (pwdata),
    .cfg_rdata_o  (prdata),
    .out_valid_o  (m_tvalid_o),
    .out_ready_i  (m_tready_i),
    .out_status_o (ostat),
    .out_page_o   (opage),
    .out_addr_o   (oaddr),
    .out_last_o   (m_tlast_o)
  );

  assign m_tdata_o = {7'd0, oaddr, opage, ostat};
  assign pready    = 1'b1;

endmodule
